/* rtl/core/u8sv_pkg.sv */
`default_nettype none

package u8sv_pkg;

  localparam int unsigned CodeW = 21;

  // Lead byte ranges and continuation byte tag
  localparam logic [7:0] AsciiMax  = 8'h7f;
  localparam logic [7:0] Lead2Min  = 8'hc2;
  localparam logic [7:0] Lead2Max  = 8'hdf;
  localparam logic [7:0] Lead3Min  = 8'he0;
  localparam logic [7:0] Lead3Max  = 8'hef;
  localparam logic [7:0] Lead4Min  = 8'hf0;
  localparam logic [7:0] Lead4Max  = 8'hf4;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContTag   = 8'h80;

  // Code point limits
  localparam logic [CodeW-1:0] Min2      = 21'h000080;
  localparam logic [CodeW-1:0] Min3      = 21'h000800;
  localparam logic [CodeW-1:0] Min4      = 21'h010000;
  localparam logic [CodeW-1:0] CodeMax   = 21'h10ffff;
  localparam logic [CodeW-1:0] SurrLow   = 21'h00d800;
  localparam logic [CodeW-1:0] SurrHigh  = 21'h00dfff;

  // Sequence length classes
  localparam logic [1:0] LenNone  = 2'd0;
  localparam logic [1:0] LenTwo   = 2'd1;
  localparam logic [1:0] LenThree = 2'd2;
  localparam logic [1:0] LenFour  = 2'd3;

  typedef struct packed {
    logic [1:0]       pending;
    logic [CodeW-1:0] accum;
    logic [1:0]       len_class;
    logic             err;
  } u8sv_state_t;

endpackage

`default_nettype wire

/* rtl/core/u8sv_step.sv */
`default_nettype none

module u8sv_step
  import u8sv_pkg::*;
(
  input  u8sv_state_t cur,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output u8sv_state_t nxt,
  output logic        verdict
);

  logic [CodeW-1:0] shifted;
  logic [CodeW-1:0] minimum;
  logic [1:0]       pend_dec;
  u8sv_state_t      upd;

  assign shifted  = {cur.accum[CodeW-7:0], data_byte[5:0]};
  assign pend_dec = cur.pending - 2'd1;

  always_comb begin
    unique case (cur.len_class)
      LenTwo:   minimum = Min2;
      LenThree: minimum = Min3;
      default:  minimum = Min4;
    endcase
  end

  always_comb begin
    upd = cur;
    if (!cur.err) begin
      if (cur.pending == 2'd0) begin
        // lead byte
        if (data_byte <= AsciiMax) begin
          if (data_byte == 8'h00) begin
            upd.err = 1'b1;
          end
        end else if (data_byte >= Lead2Min && data_byte <= Lead2Max) begin
          upd.pending   = 2'd1;
          upd.accum     = {{(CodeW-5){1'b0}}, data_byte[4:0]};
          upd.len_class = LenTwo;
        end else if (data_byte >= Lead3Min && data_byte <= Lead3Max) begin
          upd.pending   = 2'd2;
          upd.accum     = {{(CodeW-4){1'b0}}, data_byte[3:0]};
          upd.len_class = LenThree;
        end else if (data_byte >= Lead4Min && data_byte <= Lead4Max) begin
          upd.pending   = 2'd3;
          upd.accum     = {{(CodeW-3){1'b0}}, data_byte[2:0]};
          upd.len_class = LenFour;
        end else begin
          upd.err = 1'b1;
        end
      end else if ((data_byte & ContMask) != ContTag) begin
        upd.err = 1'b1;
      end else begin
        upd.accum   = shifted;
        upd.pending = pend_dec;
        if (pend_dec == 2'd0) begin
          // sequence complete: check shortest form, range, surrogates
          if (shifted < minimum || shifted > CodeMax ||
              (shifted >= SurrLow && shifted <= SurrHigh)) begin
            upd.err = 1'b1;
          end
          upd.accum     = '0;
          upd.len_class = LenNone;
        end
      end
    end
  end

  assign verdict = !upd.err && (upd.pending == 2'd0);

  always_comb begin
    if (last_byte) begin
      nxt = '0;
    end else begin
      nxt = upd;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/utf8_strict_validator.sv */
// Strict UTF-8 string checker.
// Input channel (in_*): one byte of a string per item in in_tdata, with
// in_tlast high on the final byte of each string. Every string has at least
// one byte. Output channel (out_*): one item per string, out_tdata[0] high
// when the string is shortest-form UTF-8 with no NUL byte, no surrogate code
// point, nothing above 10FFFF and no sequence cut off by the final byte.
// Timing: one input item per cycle, sustained while no final byte waits
// for the output register. Each byte is captured in an input register,
// goes through one pass of decode and range-check logic, and the verdict
// for a final byte lands in the output register, which drives out_tvalid.
// When the receiver stalls, the verdict holds in the output register; the
// block keeps taking non-final bytes, and stops taking items only once a
// second verdict would have to be written while the first still waits.
// Reset (rst_n low, synchronous) empties both registers and clears the
// running sequence state; the next byte starts a new string.
`default_nettype none

module utf8_strict_validator
  import u8sv_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] data_byte
  input  wire logic       in_tlast,   // last_byte
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata   // [0] string_valid, [7:1] zero
);

  // input register
  logic        s0_valid_r;
  logic [7:0]  s0_byte_r;
  logic        s0_last_r;

  // running sequence state
  u8sv_state_t st_r;
  u8sv_state_t st_nxt;
  logic        verdict;

  // output register
  logic        out_valid_r;
  logic        out_bit_r;

  logic        out_free;
  logic        s0_fire;
  logic        in_fire;

  // The output register is free when empty or being emptied this cycle.
  assign out_free  = !out_valid_r || out_tready;
  // A non-final byte only updates state; a final byte also needs the
  // output register.
  assign s0_fire   = s0_valid_r && (!s0_last_r || out_free);
  assign in_tready = !s0_valid_r || s0_fire;
  assign in_fire   = in_tvalid && in_tready;

  u8sv_step u_step (
    .cur       (st_r),
    .data_byte (s0_byte_r),
    .last_byte (s0_last_r),
    .nxt       (st_nxt),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      st_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // capture the next byte, or drop the stage once it has been consumed
      if (in_fire) begin
        s0_valid_r <= 1'b1;
      end else if (s0_fire) begin
        s0_valid_r <= 1'b0;
      end
      // advance the sequence state; a final byte returns it to reset
      if (s0_fire) begin
        st_r <= st_nxt;
      end
      // load a verdict, or release the one just taken
      if (s0_fire && s0_last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s0_byte_r <= in_tdata;
      s0_last_r <= in_tlast;
    end
    if (s0_fire && s0_last_r) begin
      out_bit_r <= verdict;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_bit_r};

  // Continuation bytes still owed never exceed the length of the sequence.
  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.pending <= st_r.len_class)
    else $error("pending count exceeds sequence length");

  // Outside a multi-byte sequence nothing is being assembled.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.len_class == LenNone) |-> (st_r.accum == '0 && st_r.pending == 2'd0))
    else $error("accumulator or pending count set outside a sequence");

  // A consumed final byte always produces a verdict in the next cycle.
  a_verdict_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && s0_last_r) |=> out_valid_r)
    else $error("final byte consumed without a verdict");

  // A consumed final byte leaves the state at its reset value.
  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && s0_last_r) |=> (st_r == '0))
    else $error("state not cleared after final byte");

  // A final byte is never consumed while an untaken verdict would be lost.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s0_fire && s0_last_r) |-> (!out_valid_r || out_tready))
    else $error("verdict overwritten before it was taken");

endmodule

`default_nettype wire
